/* hw/rtl/tap_tempo_detector_assert.svh */
// Assertion macros for the tap tempo detector checker
`ifndef TAP_TEMPO_DETECTOR_ASSERT_SVH
`define TAP_TEMPO_DETECTOR_ASSERT_SVH

// Same-cycle implication, masked during reset
`define TTD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define TTD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked through reset
`define TTD_ASSERT_NXT_ALL(name, clk, ante, cons, msg) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ttd_pkg.sv */
`timescale 1ns / 1ps

package ttd_pkg;

    // Default depth of the tap store
    localparam int MAX_TAPS_DEF = 8;

    // A tempo is computed from this many taps on
    localparam int MIN_TAPS = 3;

    // 60000 ms per minute, scaled to Q16.8
    localparam int TEMPO_NUM = 60000 * 256;

    localparam int BPM_W = 24;
    localparam int TS_W  = 32;
    localparam int INT_W = 16;

    localparam logic [BPM_W-1:0] BPM_MAX  = 24'hFF_FFFF;
    localparam logic [BPM_W-1:0] DRIFT_Q8 = 24'd12800;

    localparam logic [INT_W-1:0] MIN_INTERVAL_RST = 16'd100;
    localparam logic [INT_W-1:0] MAX_INTERVAL_RST = 16'd3000;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_INTERVAL = 2'd1;

    // Request kinds
    localparam logic ACT_TAP   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DEBOUNCED  = 3'd0,
        ST_COLLECTING = 3'd1,
        ST_UPDATED    = 3'd2,
        ST_DRIFT      = 3'd3,
        ST_CLEARED    = 3'd4
    } t_status;

    // Control sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PUSH,
        S_SPAN,
        S_DIV,
        S_DRIFT,
        S_FIN
    } t_state;

endpackage

/* hw/rtl/ttd_ring.sv */
`timescale 1ns / 1ps

module ttd_ring #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ttd_div.sv */
`timescale 1ns / 1ps

module ttd_div #(
    parameter int NUM_W = 27,
    parameter int DEN_W = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   trial;
    logic             fits;

    // Restoring step: shift in the next numerator bit, subtract if it fits
    assign trial = {r_rem, r_quo[NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: numerator bits leave at the top as quotient bits enter below
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

/* hw/rtl/tap_tempo_detector.sv */
`timescale 1ns / 1ps
// Channel      | Dir | Signals                      | Contents
// -------------+-----+------------------------------+------------------------------------
// tap request  | in  | i_s_tvalid/o_s_tready        | tdata: now_ms[31:0]; tuser: action
// tempo result | out | o_m_tvalid/i_m_tready        | tdata: bpm_q8[23:0]; tuser: status
// config write | in  | i_cfg_we/i_cfg_idx/i_cfg_data| 0: min_interval_ms, 1: max_interval_ms
//
// A tempo tap waits on the bit-serial divider, which retires one quotient bit per
// cycle. One request is in work at a time.
// Reset is synchronous; it clears tap count, tempo, head and output valid. The tap store is
// not cleared, entries past the count are never read. A result waits in the output
// register while the next request is taken; a stalled output only holds back the
// result of the following request.

module tap_tempo_detector #(
    parameter int MAX_TAPS = ttd_pkg::MAX_TAPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Tap request
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [31:0]                i_s_tdata,   // [31:0] now_ms
    input  logic                       i_s_tuser,   // [0] action
    // Tempo result
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [23:0]                o_m_tdata,   // [23:0] bpm_q8
    output logic [2:0]                 o_m_tuser,   // [2:0] status
    // Configuration
    input  logic                       i_cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                i_cfg_data
);

    import ttd_pkg::*;

    localparam int PTR_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int NUM_W = $clog2(TEMPO_NUM * (MAX_TAPS - 1) + 1);

    t_state            r_state, n_state;
    logic [INT_W-1:0]  r_min, r_max;
    logic [PTR_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ivals, n_ivals;
    logic [BPM_W-1:0]  r_bpm, n_bpm;
    logic [BPM_W-1:0]  r_fresh, n_fresh;
    logic [TS_W-1:0]   r_now, n_now;
    logic [BPM_W-1:0]  r_res_bpm, n_res_bpm;
    t_status           r_res_st, n_res_st;
    logic              r_out_valid, n_out_valid;
    logic [BPM_W-1:0]  r_out_bpm, n_out_bpm;
    t_status           r_out_st, n_out_st;

    logic              in_acc;
    logic              mem_we, mem_re;
    logic [PTR_W-1:0]  mem_waddr, mem_raddr;
    logic [TS_W-1:0]   mem_rdata;
    logic              div_start, div_done;
    logic [NUM_W-1:0]  div_num, div_quo;

    logic [TS_W-1:0]   gap;
    logic [PTR_W-1:0]  head_inc;
    logic [CNT_W-1:0]  cnt_new;
    logic [PTR_W:0]    old_sum;
    logic [PTR_W-1:0]  old_addr;
    logic [BPM_W-1:0]  drift_diff;
    logic [BPM_W-1:0]  quo_sat;

    // Tap timestamp ring, newest entry at r_head
    ttd_ring #(
        .DEPTH (MAX_TAPS),
        .AW    (PTR_W),
        .DW    (TS_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_now),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Tempo divider
    ttd_div #(
        .NUM_W (NUM_W),
        .DEN_W (TS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (gap),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign in_acc = i_s_tvalid && o_s_tready;

    // Shared datapath terms
    assign gap      = r_now - mem_rdata;
    assign head_inc = (r_head == PTR_W'(MAX_TAPS - 1)) ? '0 : r_head + 1'b1;
    assign cnt_new  = (r_count < CNT_W'(MAX_TAPS)) ? r_count + 1'b1 : CNT_W'(MAX_TAPS);
    // Oldest kept tap after the push sits (cnt_new - 2) entries behind the old head
    assign old_sum  = {1'b0, r_head} + (PTR_W+1)'(MAX_TAPS) - (PTR_W+1)'(cnt_new - 2'd2);
    assign old_addr = (old_sum >= (PTR_W+1)'(MAX_TAPS)) ?
                      PTR_W'(old_sum - (PTR_W+1)'(MAX_TAPS)) : old_sum[PTR_W-1:0];
    assign div_num  = NUM_W'(TEMPO_NUM) * NUM_W'(r_ivals);
    assign quo_sat  = (div_quo > NUM_W'(BPM_MAX)) ? BPM_MAX : div_quo[BPM_W-1:0];
    assign drift_diff = (r_fresh > r_bpm) ? r_fresh - r_bpm : r_bpm - r_fresh;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_INTERVAL_RST;
            r_max <= MAX_INTERVAL_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_MIN_INTERVAL) begin
                r_min <= i_cfg_data;
            end
            if (i_cfg_idx == REG_MAX_INTERVAL) begin
                r_max <= i_cfg_data;
            end
        end
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_bpm       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_bpm       <= n_bpm;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ivals   <= n_ivals;
        r_fresh   <= n_fresh;
        r_now     <= n_now;
        r_res_bpm <= n_res_bpm;
        r_res_st  <= n_res_st;
        r_out_bpm <= n_out_bpm;
        r_out_st  <= n_out_st;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_ivals     = r_ivals;
        n_bpm       = r_bpm;
        n_fresh     = r_fresh;
        n_now       = r_now;
        n_res_bpm   = r_res_bpm;
        n_res_st    = r_res_st;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_bpm   = r_out_bpm;
        n_out_st    = r_out_st;
        o_s_tready  = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = head_inc;
        mem_re      = 1'b0;
        mem_raddr   = r_head;
        div_start   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (in_acc) begin
                    n_now = i_s_tdata;
                    if (i_s_tuser == ACT_CLEAR) begin
                        n_count   = '0;
                        n_bpm     = '0;
                        n_res_bpm = '0;
                        n_res_st  = ST_CLEARED;
                        n_state   = S_FIN;
                    end else if (r_count == '0) begin
                        n_state = S_PUSH;
                    end else begin
                        // fetch newest tap
                        mem_re  = 1'b1;
                        n_state = S_CHECK;
                    end
                end
            end

            // Gap to the newest tap: debounce or late restart
            S_CHECK: begin
                if (gap < TS_W'(r_min)) begin
                    n_res_bpm = r_bpm;
                    n_res_st  = ST_DEBOUNCED;
                    n_state   = S_FIN;
                end else begin
                    if (gap > TS_W'(r_max)) begin
                        n_count = '0;
                        n_bpm   = '0;
                    end
                    n_state = S_PUSH;
                end
            end

            // Store the tap; fetch the oldest kept tap when a tempo is due
            S_PUSH: begin
                mem_we  = 1'b1;
                n_head  = head_inc;
                n_count = cnt_new;
                n_ivals = cnt_new - 1'b1;
                if (cnt_new < CNT_W'(MIN_TAPS)) begin
                    n_res_bpm = r_bpm;
                    n_res_st  = ST_COLLECTING;
                    n_state   = S_FIN;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = old_addr;
                    n_state   = S_SPAN;
                end
            end

            // Span known: start the divide, or zero tempo on a zero span
            S_SPAN: begin
                if (gap == '0) begin
                    n_fresh = '0;
                    n_state = S_DRIFT;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end

            S_DIV: begin
                if (div_done) begin
                    n_fresh = quo_sat;
                    n_state = S_DRIFT;
                end
            end

            // Reject a jump over 50 BPM and restart the run at this tap
            S_DRIFT: begin
                if (r_bpm != '0 && drift_diff > DRIFT_Q8) begin
                    n_count   = CNT_W'(1);
                    n_res_bpm = r_bpm;
                    n_res_st  = ST_DRIFT;
                end else begin
                    n_bpm     = r_fresh;
                    n_res_bpm = r_fresh;
                    n_res_st  = ST_UPDATED;
                end
                n_state = S_FIN;
            end

            // Hand the result to the output register once it is free
            S_FIN: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_bpm   = r_res_bpm;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_bpm;
    assign o_m_tuser  = r_out_st;

endmodule

/* hw/rtl/tap_tempo_detector_chk.sv */
`timescale 1ns / 1ps
`include "tap_tempo_detector_assert.svh"

module tap_tempo_detector_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,
    input  logic                          i_s_tuser,
    input  logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [23:0]                   o_m_tdata,
    input  logic [2:0]                    o_m_tuser,
    input  logic                          i_cfg_we,
    input  logic [ttd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [15:0]                   i_cfg_data
);

    import ttd_pkg::*;

    logic [23:0] r_last_bpm;
    logic        kept_bpm;

    // Tempo carried by the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_bpm <= '0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_last_bpm <= o_m_tdata;
        end
    end

    assign kept_bpm = (o_m_tuser == ST_DEBOUNCED) || (o_m_tuser == ST_DRIFT);

    // Stalled result holds
    `TTD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

    // Clear always reports zero tempo
    `TTD_ASSERT_IMP(a_clear_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tuser == ST_CLEARED, o_m_tdata == '0, "clear result with nonzero tempo")

    // Debounced and rejected taps leave the tempo untouched
    `TTD_ASSERT_IMP(a_keep_bpm, i_clk, i_rst_n, o_m_tvalid && kept_bpm, o_m_tdata == r_last_bpm, "tempo changed on an ignored tap")

    // One request in work at a time
    `TTD_ASSERT_NXT(a_one_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "request taken while busy")

    // Reset empties the output
    `TTD_ASSERT_NXT_ALL(a_rst_out, i_clk, !i_rst_n, !o_m_tvalid, "result valid after reset")

    // Config port is not checked here
    logic unused_cfg;
    assign unused_cfg = i_cfg_we ^ (^i_cfg_idx) ^ (^i_cfg_data) ^ (^i_s_tdata) ^ i_s_tuser;

endmodule

bind tap_tempo_detector tap_tempo_detector_chk u_tap_tempo_detector_chk (.*);

/* test/tap_tempo_detector_test.sv */
`timescale 1ns / 1ps

module tap_tempo_detector_test;
    import ttd_pkg::*;

    localparam int TAP_DEPTH   = MAX_TAPS_DEF;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYC  = 50;
    localparam int HOLD_CYC    = 400;
    localparam int MAX_REPORTS = 10;

    // Indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef enum int {RX_STEADY, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_mode;

    typedef struct {
        logic [BPM_W-1:0] bpm;
        t_status          st;
    } t_tempo_result;

    // One row of the directed script: either a register write or a request
    typedef struct {
        bit                   cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic                 act;
        logic [31:0]          val;
        bit                   typed;
        logic [BPM_W-1:0]     bpm;
        t_status              st;
    } t_script_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [31:0]          i_s_tdata;
    logic                 i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [23:0]          o_m_tdata;
    logic [2:0]           o_m_tuser;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [15:0]          i_cfg_data;

    // Predictor state
    logic [31:0]      tap_ts [TAP_DEPTH];
    int unsigned      n_taps = 0;
    logic [BPM_W-1:0] cur_tempo = '0;
    logic [15:0]      min_gap = MIN_INTERVAL_RST;
    logic [15:0]      max_gap = MAX_INTERVAL_RST;
    logic [31:0]      stamp = '0;

    t_tempo_result tempo_due_q [$];
    int            fault_count = 0;
    int            quiet_cycles = 0;
    int            rx_hold_left = 0;

    localparam int SCRIPT_LEN = 30;
    t_script_row script [SCRIPT_LEN] = '{
        // first tap, then one too soon, then a second tap
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd0,          1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd50,         1'b1, 24'd0, ST_DEBOUNCED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd500,        1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd1000,       1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd1500,       1'b0, 24'd0, ST_UPDATED},
        // gap exactly at the minimum
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd1600,       1'b0, 24'd0, ST_UPDATED},
        // tempo jump beyond the drift window
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd3200,       1'b0, 24'd0, ST_DRIFT},
        // one past the maximum gap: run restarts, tempo cleared
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd6201,       1'b1, 24'd0, ST_COLLECTING},
        // gap exactly at the maximum
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd9201,       1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd9301,       1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_CLEAR, 32'hFFFF_FFFF,  1'b1, 24'd0, ST_CLEARED},
        // run across the timestamp wrap, then fill the store and overflow it
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'hFFFF_FF00,  1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0100,  1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0300,  1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0500,  1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0700,  1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0900,  1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0B00,  1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0D00,  1'b0, 24'd0, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'h0000_0F00,  1'b0, 24'd0, ST_UPDATED},
        // no debounce; a write to a missing register changes nothing
        '{1'b1, REG_MIN_INTERVAL, ACT_TAP,   32'd0,          1'b0, 24'd0, ST_DEBOUNCED},
        '{1'b1, REG_SPARE_A,      ACT_TAP,   32'h0000_FFFF,  1'b0, 24'd0, ST_DEBOUNCED},
        '{1'b0, REG_MIN_INTERVAL, ACT_CLEAR, 32'd0,          1'b1, 24'd0, ST_CLEARED},
        // two taps at the same time then one 1 ms later: saturates
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd5,          1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd5,          1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd6,          1'b1, BPM_MAX, ST_UPDATED},
        '{1'b0, REG_MIN_INTERVAL, ACT_CLEAR, 32'h5A5A_A5A5,  1'b1, 24'd0, ST_CLEARED},
        // zero span gives zero tempo
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd9,          1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd9,          1'b1, 24'd0, ST_COLLECTING},
        '{1'b0, REG_MIN_INTERVAL, ACT_TAP,   32'd9,          1'b1, 24'd0, ST_UPDATED}
    };

    tap_tempo_detector #(
        .MAX_TAPS (TAP_DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Tempo predictor: updates the shadow state for one accepted request
    function automatic void predict_tempo(input logic act, input logic [31:0] ts,
                                          output logic [BPM_W-1:0] bpm, output t_status st);
        int unsigned      cnt;
        int               shift;
        logic [31:0]      gap;
        logic [31:0]      span;
        logic [63:0]      quot;
        logic [BPM_W-1:0] fresh;
        logic [BPM_W-1:0] diff;
        cnt = n_taps;
        if (act == ACT_CLEAR) begin
            n_taps    = 0;
            cur_tempo = '0;
            bpm       = '0;
            st        = ST_CLEARED;
            return;
        end
        if (cnt > 0) begin
            gap = ts - tap_ts[0];
            if (gap < {16'd0, min_gap}) begin
                bpm = cur_tempo;
                st  = ST_DEBOUNCED;
                return;
            end
            if (gap > {16'd0, max_gap}) begin
                cnt       = 0;
                cur_tempo = '0;
            end
        end
        // newest first; the oldest falls off a full store
        shift = (cnt < TAP_DEPTH) ? cnt : TAP_DEPTH - 1;
        for (int i = shift; i > 0; i--) tap_ts[i] = tap_ts[i-1];
        tap_ts[0] = ts;
        if (cnt < TAP_DEPTH) cnt++;
        n_taps = cnt;
        if (cnt < MIN_TAPS) begin
            st = ST_COLLECTING;
        end else begin
            span = ts - tap_ts[cnt-1];
            if (span == 0) begin
                fresh = '0;
            end else begin
                quot  = (64'(TEMPO_NUM) * 64'(cnt - 1)) / {32'd0, span};
                fresh = (quot > {40'd0, BPM_MAX}) ? BPM_MAX : quot[BPM_W-1:0];
            end
            diff = (fresh > cur_tempo) ? fresh - cur_tempo : cur_tempo - fresh;
            if (cur_tempo != 0 && diff > DRIFT_Q8) begin
                n_taps = 1;
                st     = ST_DRIFT;
            end else begin
                cur_tempo = fresh;
                st        = ST_UPDATED;
            end
        end
        bpm = cur_tempo;
    endfunction

    function automatic void log_fault(input string what);
        fault_count++;
        if (fault_count <= MAX_REPORTS) $display("%0t ns: %s", $time, what);
    endfunction

    // Offer one request and hold it until taken; valid stays high on return
    task automatic send_tap(input logic act, input logic [31:0] ts, input bit typed,
                            input logic [BPM_W-1:0] t_bpm, input t_status t_st);
        t_tempo_result due;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= ts;
        do @(posedge i_clk); while (!o_s_tready);
        predict_tempo(act, ts, due.bpm, due.st);
        if (typed) begin
            due.bpm = t_bpm;
            due.st  = t_st;
        end
        tempo_due_q.push_back(due);
    endtask

    task automatic idle_sender(input int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Stop offering until every expected result has come back
    task automatic await_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (tempo_due_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        await_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MIN_INTERVAL) min_gap = data;
        else if (idx == REG_MAX_INTERVAL) max_gap = data;
    endtask

    function automatic logic [31:0] pick_period();
        if (min_gap > max_gap) return {16'd0, min_gap};
        if (min_gap <= 300 && max_gap >= 1200 && $urandom_range(0, 1) == 1)
            return $urandom_range(300, 1200);
        return $urandom_range(min_gap, max_gap);
    endfunction

    // Mostly steady tap runs; the rest are early, late, boundary, clear and stray taps, period changes and pauses
    task automatic run_taps(input int n_items, input bit bursty);
        int          burst;
        int unsigned roll;
        logic [31:0] period;
        logic [31:0] base;
        logic [31:0] ts;
        logic        act;
        burst  = 0;
        period = pick_period();
        for (int k = 0; k < n_items; k++) begin
            if (bursty) begin
                if (burst == 0) begin
                    idle_sender($urandom_range(1, 30));
                    burst = $urandom_range(1, 20);
                end
                burst--;
            end
            base = (n_taps > 0) ? tap_ts[0] : stamp;
            act  = ACT_TAP;
            roll = $urandom_range(0, 99);
            if (roll < 64) begin
                ts = base + period + $urandom_range(0, period / 32);
            end else if (roll < 72) begin
                ts = base + ((min_gap == 0) ? 32'd0 : $urandom_range(0, min_gap - 1));
            end else if (roll < 79) begin
                ts = base + {16'd0, max_gap} + 32'd1 + $urandom_range(0, 4000);
            end else if (roll < 85) begin
                case ($urandom_range(0, 3))
                    0: ts = base + {16'd0, min_gap} - 32'd1;
                    1: ts = base + {16'd0, min_gap};
                    2: ts = base + {16'd0, max_gap};
                    default: ts = base + {16'd0, max_gap} + 32'd1;
                endcase
            end else if (roll < 89) begin
                act = ACT_CLEAR;
                ts  = $urandom;
            end else if (roll < 93) begin
                ts = $urandom;
            end else if (roll < 98) begin
                period = pick_period();
                ts     = base + period;
            end else begin
                await_results();
                ts = base + period;
            end
            send_tap(act, ts, 1'b0, '0, ST_DEBOUNCED);
            stamp = ts;
        end
    endtask

    task automatic run_phase(input logic [15:0] lo, input logic [15:0] hi, input int n_items,
                             input bit bursty, input bit hold);
        write_reg(REG_MIN_INTERVAL, lo);
        write_reg(REG_MAX_INTERVAL, hi);
        if (hold) rx_hold_left = HOLD_CYC;
        run_taps(n_items, bursty);
    endtask

    // Result side: stall patterns picked anew every segment, plus an optional long hold
    initial begin : rx_side
        t_rx_mode    mode;
        int          seg_left;
        int unsigned tick;
        mode       = RX_STEADY;
        seg_left   = 0;
        tick       = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (rx_hold_left > 0) begin
                i_m_tready <= 1'b0;
                rx_hold_left--;
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 3));
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    RX_STEADY:  i_m_tready <= 1'b1;
                    RX_COIN:    i_m_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: i_m_tready <= (tick % 5) < 3;
                    default:    i_m_tready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_tempo_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (tempo_due_q.size() == 0) begin
                log_fault($sformatf("unexpected result bpm %0d status %0d",
                                    o_m_tdata, o_m_tuser));
            end else begin
                want = tempo_due_q.pop_front();
                if (o_m_tdata !== want.bpm || o_m_tuser !== want.st)
                    log_fault($sformatf("bpm exp %0d got %0d, status exp %0d got %0d",
                                        want.bpm, o_m_tdata, want.st, o_m_tuser));
            end
        end
    end

    // Watchdog: too long without any transfer
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [15:0] lo;
        logic [15:0] hi;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= ACT_TAP;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= REG_MIN_INTERVAL;
        i_cfg_data <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed script at reset settings
        for (int r = 0; r < SCRIPT_LEN; r++) begin
            if (script[r].cfg)
                write_reg(script[r].idx, script[r].val[15:0]);
            else
                send_tap(script[r].act, script[r].val, script[r].typed,
                         script[r].bpm, script[r].st);
        end

        // random phases over several register settings, extremes first
        run_phase(16'd0, 16'hFFFF, 200, 1'b1, 1'b0);
        run_phase(16'hFFFF, 16'd0, 60, 1'b1, 1'b0);
        run_phase(16'd0, 16'd0, 60, 1'b1, 1'b0);
        write_reg(REG_SPARE_B, 16'h1234);
        run_phase(16'hFFFF, 16'hFFFF, 60, 1'b1, 1'b0);
        run_phase(16'd80, 16'd2000, 300, 1'b1, 1'b1);
        lo = 16'($urandom_range(0, 400));
        hi = 16'($urandom_range(lo, 5000));
        run_phase(lo, hi, 200, 1'b1, 1'b0);
        run_phase(MIN_INTERVAL_RST, MAX_INTERVAL_RST, 300, 1'b0, 1'b0);

        await_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (tempo_due_q.size() != 0)
            log_fault($sformatf("%0d results never arrived", tempo_due_q.size()));
        if (fault_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* tap_tempo_detector.f */
+incdir+hw/rtl
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_ring.sv
hw/rtl/ttd_div.sv
hw/rtl/tap_tempo_detector.sv
hw/rtl/tap_tempo_detector_chk.sv
test/tap_tempo_detector_test.sv
